// File: rtl/rcnc_pkg.sv
// Shared widths, register indexes and node kinds for the node coordinate pipeline.
package rcnc_pkg;

    localparam int CNT_W   = 10;  // cell count register width
    localparam int SIZE_W  = 30;  // size / centre register width
    localparam int IDX_W   = 21;  // node index width
    localparam int INNER_W = 20;  // holds nx*ny
    localparam int OUT_W   = 31;  // coordinate width
    localparam int BND_W   = 12;  // boundary offset, up to 2*(nx+ny)
    localparam int CFG_W   = 3;   // register index width

    typedef enum logic [CFG_W-1:0] {
        CFG_CELLS_X  = 3'd0,
        CFG_CELLS_Y  = 3'd1,
        CFG_WIDTH_X  = 3'd2,
        CFG_HEIGHT_Y = 3'd3,
        CFG_CENTRE_X = 3'd4,
        CFG_CENTRE_Y = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_INNER  = 3'd0,
        KIND_TOP    = 3'd1,
        KIND_RIGHT  = 3'd2,
        KIND_BOTTOM = 3'd3,
        KIND_LEFT   = 3'd4
    } node_kind_t;

    localparam logic [1:0] NORM_ZERO = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

endpackage

// File: rtl/rect_collocation_node_coords.sv
// Top level: node index to collocation node coordinate and normal, pipelined.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready | tdata: node_index
//  m_      | out | m_tvalid/m_tready | tdata: coord_x, coord_y, normal_x, normal_y
//          |     |                   | tuser: on_boundary, index_error
//  cfg_    | in  | cfg_we            | cfg_index selects register, cfg_data value
//
// One transfer in per cycle while the output is not stalled. The pipe holds the
// row/column divider (21 stages) and the two midpoint dividers (31 stages),
// plus plain stages before, between and after them.
// rst_n clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipe; an empty first stage still takes input.
module rect_collocation_node_coords (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // [20:0] node_index
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [71:0]                      m_tdata,   // [30:0] coord_x, [61:31] coord_y,
                                                        // [63:62] normal_x, [65:64] normal_y
    output logic [1:0]                       m_tuser,   // [0] on_boundary, [1] index_error
    input  logic                             cfg_we,
    input  logic [rcnc_pkg::CFG_W-1:0]       cfg_index,
    input  logic [rcnc_pkg::SIZE_W-1:0]      cfg_data
);

    localparam int CW  = rcnc_pkg::CNT_W;
    localparam int SW  = rcnc_pkg::SIZE_W;
    localparam int IW  = rcnc_pkg::IDX_W;
    localparam int NW  = rcnc_pkg::INNER_W;
    localparam int OW  = rcnc_pkg::OUT_W;
    localparam int BW  = rcnc_pkg::BND_W;
    localparam int MQW = SW;           // midpoint quotient below size
    localparam int MDW = CW + 1;       // divisor 2n
    localparam int MNW = SW + CW + 1;  // (2k+1)*size

    // ---------------- configuration registers ----------------
    logic [CW-1:0] cells_x_reg, cells_y_reg;
    logic [SW-1:0] width_x_reg, height_y_reg;
    logic [SW-1:0] centre_x_reg, centre_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg  <= CW'(1);
            cells_y_reg  <= CW'(1);
            width_x_reg  <= SW'(65536);
            height_y_reg <= SW'(65536);
            centre_x_reg <= '0;
            centre_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcnc_pkg::CFG_CELLS_X:  cells_x_reg  <= cfg_data[CW-1:0];
                rcnc_pkg::CFG_CELLS_Y:  cells_y_reg  <= cfg_data[CW-1:0];
                rcnc_pkg::CFG_WIDTH_X:  width_x_reg  <= cfg_data;
                rcnc_pkg::CFG_HEIGHT_Y: height_y_reg <= cfg_data;
                rcnc_pkg::CFG_CENTRE_X: centre_x_reg <= cfg_data;
                rcnc_pkg::CFG_CENTRE_Y: centre_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero count behaves as one
    logic [CW-1:0] nx, ny;
    assign nx = (cells_x_reg == '0) ? CW'(1) : cells_x_reg;
    assign ny = (cells_y_reg == '0) ? CW'(1) : cells_y_reg;

    // ---------------- flow control ----------------
    logic out_v_reg;
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v5_reg, v7_reg;
    logic d1_valid, d2_valid;

    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv || !v1_reg;

    // ---------------- stage 1: capture ----------------
    logic [IW-1:0] i1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            i1_reg <= s_tdata[IW-1:0];
        end
    end

    // ---------------- stage 2: inner node count ----------------
    logic [IW-1:0] i2_reg;
    logic [NW-1:0] inner2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i2_reg     <= i1_reg;
            inner2_reg <= NW'(nx) * NW'(ny);
        end
    end

    // ---------------- stage 3: range check ----------------
    logic [IW-1:0] total2;
    logic [IW-1:0] bdiff2;
    logic [IW-1:0] i3_reg;
    logic [BW-1:0] b3_reg;
    logic          inner3_reg, err3_reg;

    assign total2 = IW'(inner2_reg) + IW'({(CW+1)'(nx) + (CW+1)'(ny), 1'b0});
    assign bdiff2 = i2_reg - IW'(inner2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i3_reg     <= i2_reg;
            b3_reg     <= bdiff2[BW-1:0];
            inner3_reg <= i2_reg <= IW'(inner2_reg);
            err3_reg   <= (i2_reg == '0) || (i2_reg > total2);
        end
    end

    // ---------------- boundary side and offset, into row/col divider ----------------
    rcnc_pkg::node_kind_t kind3;
    logic [BW-1:0]        kb3_full;
    logic [BW-1:0]        lim1, lim2, lim3;
    logic [NW-1:0]        idx3;

    assign lim1 = BW'(nx);
    assign lim2 = BW'(nx) + BW'(ny);
    assign lim3 = lim2 + BW'(nx);
    assign idx3 = NW'(i3_reg - IW'(1));

    always_comb
    begin
        if (inner3_reg)
        begin
            kind3    = rcnc_pkg::KIND_INNER;
            kb3_full = '0;
        end
        else if (b3_reg <= lim1)
        begin
            kind3    = rcnc_pkg::KIND_TOP;
            kb3_full = b3_reg - BW'(1);
        end
        else if (b3_reg <= lim2)
        begin
            kind3    = rcnc_pkg::KIND_RIGHT;
            kb3_full = b3_reg - lim1 - BW'(1);
        end
        else if (b3_reg <= lim3)
        begin
            kind3    = rcnc_pkg::KIND_BOTTOM;
            kb3_full = b3_reg - lim2 - BW'(1);
        end
        else
        begin
            kind3    = rcnc_pkg::KIND_LEFT;
            kb3_full = b3_reg - lim3 - BW'(1);
        end
    end

    localparam int S1W = 1 + 3 + CW;
    logic [NW-1:0]  d1_quo;
    logic [CW-1:0]  d1_rem;
    logic [S1W-1:0] d1_side;

    rcnc_div #(
        .LANES  (1),
        .DEN_W  (CW),
        .Q_W    (NW),
        .SIDE_W (S1W)
    ) u_div_rc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .den       (nx),
        .rem_in    ({CW{1'b0}}),
        .num_in    (inner3_reg ? idx3 : NW'(0)),
        .side_in   ({err3_reg, kind3, kb3_full[CW-1:0]}),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .rem       (d1_rem),
        .side_out  (d1_side)
    );

    // ---------------- stage 5: cell index per axis ----------------
    rcnc_pkg::node_kind_t kind_d1;
    logic [CW-1:0]        kb_d1;
    logic [CW-1:0]        kx5_next, ky5_next;
    logic [CW-1:0]        kx5_reg, ky5_reg;
    rcnc_pkg::node_kind_t kind5_reg;
    logic                 err5_reg;

    assign kind_d1 = rcnc_pkg::node_kind_t'(d1_side[CW+2:CW]);
    assign kb_d1   = d1_side[CW-1:0];

    always_comb
    begin
        case (kind_d1)
            rcnc_pkg::KIND_INNER:
            begin
                kx5_next = d1_rem;
                ky5_next = d1_quo[CW-1:0];
            end
            rcnc_pkg::KIND_TOP, rcnc_pkg::KIND_BOTTOM:
            begin
                kx5_next = kb_d1;
                ky5_next = '0;
            end
            default:
            begin
                kx5_next = '0;
                ky5_next = kb_d1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kx5_reg   <= kx5_next;
            ky5_reg   <= ky5_next;
            kind5_reg <= kind_d1;
            err5_reg  <= d1_side[S1W-1];
        end
    end

    // ---------------- (2k+1)*size, into midpoint dividers ----------------
    logic [MNW-1:0] numx5, numy5;
    assign numx5 = MNW'({kx5_reg, 1'b1}) * MNW'(width_x_reg);
    assign numy5 = MNW'({ky5_reg, 1'b1}) * MNW'(height_y_reg);

    logic [1:0][MQW-1:0] d2_quo;
    logic [1:0][MDW-1:0] d2_rem;
    logic [3:0]          d2_side;

    rcnc_div #(
        .LANES  (2),
        .DEN_W  (MDW),
        .Q_W    (MQW),
        .SIDE_W (4)
    ) u_div_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v5_reg),
        .den       ({{ny, 1'b0}, {nx, 1'b0}}),
        .rem_in    ({numy5[MNW-1:MQW], numx5[MNW-1:MQW]}),
        .num_in    ({numy5[MQW-1:0], numx5[MQW-1:0]}),
        .side_in   ({err5_reg, kind5_reg}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .rem       (d2_rem),
        .side_out  (d2_side)
    );

    // remainders are not needed for midpoints
    logic rem_unused;
    assign rem_unused = ^d2_rem;

    // ---------------- stage 7: edge placement ----------------
    rcnc_pkg::node_kind_t kind_d2;
    logic [SW-1:0]        px7_next, py7_next, px7_reg, py7_reg;
    rcnc_pkg::node_kind_t kind7_reg;
    logic                 err7_reg;

    assign kind_d2 = rcnc_pkg::node_kind_t'(d2_side[2:0]);

    always_comb
    begin
        case (kind_d2)
            rcnc_pkg::KIND_INNER:
            begin
                px7_next = d2_quo[0];
                py7_next = d2_quo[1];
            end
            rcnc_pkg::KIND_TOP:
            begin
                px7_next = d2_quo[0];
                py7_next = height_y_reg;
            end
            rcnc_pkg::KIND_RIGHT:
            begin
                px7_next = width_x_reg;
                py7_next = height_y_reg - d2_quo[1];
            end
            rcnc_pkg::KIND_BOTTOM:
            begin
                px7_next = width_x_reg - d2_quo[0];
                py7_next = '0;
            end
            default:
            begin
                px7_next = '0;
                py7_next = d2_quo[1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px7_reg   <= px7_next;
            py7_reg   <= py7_next;
            kind7_reg <= kind_d2;
            err7_reg  <= d2_side[3] | rem_unused & 1'b0;
        end
    end

    // ---------------- output stage: shift to centre ----------------
    logic [OW-1:0] cx_next, cy_next;
    logic [1:0]    nrm_x_next, nrm_y_next;
    logic [OW-1:0] cx_reg, cy_reg;
    logic [1:0]    nrm_x_reg, nrm_y_reg;
    logic          bnd_reg, err_reg;

    // modulo 2^31 arithmetic gives the truncated result directly
    assign cx_next = OW'(px7_reg) - OW'(width_x_reg[SW-1:1])
                   + {centre_x_reg[SW-1], centre_x_reg};
    assign cy_next = OW'(py7_reg) - OW'(height_y_reg[SW-1:1])
                   + {centre_y_reg[SW-1], centre_y_reg};

    always_comb
    begin
        nrm_x_next = rcnc_pkg::NORM_ZERO;
        nrm_y_next = rcnc_pkg::NORM_ZERO;
        case (kind7_reg)
            rcnc_pkg::KIND_TOP:    nrm_y_next = rcnc_pkg::NORM_POS;
            rcnc_pkg::KIND_RIGHT:  nrm_x_next = rcnc_pkg::NORM_POS;
            rcnc_pkg::KIND_BOTTOM: nrm_y_next = rcnc_pkg::NORM_NEG;
            rcnc_pkg::KIND_LEFT:   nrm_x_next = rcnc_pkg::NORM_NEG;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg    <= err7_reg ? '0 : cx_next;
            cy_reg    <= err7_reg ? '0 : cy_next;
            nrm_x_reg <= err7_reg ? rcnc_pkg::NORM_ZERO : nrm_x_next;
            nrm_y_reg <= err7_reg ? rcnc_pkg::NORM_ZERO : nrm_y_next;
            bnd_reg   <= !err7_reg && (kind7_reg != rcnc_pkg::KIND_INNER);
            err_reg   <= err7_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, nrm_y_reg, nrm_x_reg, cy_reg, cx_reg};
    assign m_tuser  = {err_reg, bnd_reg};

endmodule

// File: rtl/rcnc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rcnc_div #(
    parameter int LANES  = 1,
    parameter int DEN_W  = 10,
    parameter int Q_W    = 20,
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [LANES-1:0][DEN_W-1:0]       den,
    input  logic [LANES-1:0][DEN_W-1:0]       rem_in,  // must be below den
    input  logic [LANES-1:0][Q_W-1:0]         num_in,
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic [LANES-1:0][Q_W-1:0]         quo,
    output logic [LANES-1:0][DEN_W-1:0]       rem,
    output logic [SIDE_W-1:0]                 side_out
);

    logic                        v_reg    [Q_W+1];
    logic [LANES-1:0][DEN_W-1:0] d_reg    [Q_W+1];
    logic [LANES-1:0][DEN_W-1:0] r_reg    [Q_W+1];
    logic [LANES-1:0][Q_W-1:0]   nq_reg   [Q_W+1];
    logic [SIDE_W-1:0]           side_reg [Q_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]    <= den;
            r_reg[0]    <= rem_in;
            nq_reg[0]   <= num_in;
            side_reg[0] <= side_in;
        end
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] r_next;
        logic [LANES-1:0][Q_W-1:0]   nq_next;

        always_comb
        begin
            logic [DEN_W:0] trial;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {r_reg[s][l], nq_reg[s][l][Q_W-1]};
                ge    = trial >= {1'b0, d_reg[s][l]};
                r_next[l]  = ge ? DEN_W'(trial - {1'b0, d_reg[s][l]}) : trial[DEN_W-1:0];
                nq_next[l] = {nq_reg[s][l][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[s+1]    <= d_reg[s];
                r_reg[s+1]    <= r_next;
                nq_reg[s+1]   <= nq_next;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign quo       = nq_reg[Q_W];
    assign rem       = r_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

// File: rtl/rcnc_chk.sv
// Port-level checks on the node coordinate results, bound to the top level.
module rcnc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // bad index gives all-zero payload and no boundary flag
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[65:0] == '0) && !m_tuser[0])
        else $error("index error with nonzero payload");

    // boundary node has exactly one nonzero normal component
    a_bnd_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> ((m_tdata[63:62] != 2'b00) != (m_tdata[65:64] != 2'b00)))
        else $error("boundary normal malformed");

    // inner node has no normal
    a_inner_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[65:62] == '0))
        else $error("inner node with normal");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output changed");

endmodule

bind rect_collocation_node_coords rcnc_chk u_rcnc_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
